// ===== sv/iidl_pkg.sv =====
// Package for the indexed insert/delete list: sizes, codes and item types.
`default_nettype none
package iidl_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the items
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int RD_W     = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Internal count width and the width used for index compares
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_APPEND = 3'd0;
    localparam t_cmd CMD_INSERT = 3'd1;
    localparam t_cmd CMD_POP    = 3'd2;
    localparam t_cmd CMD_DELETE = 3'd3;
    localparam t_cmd CMD_READ   = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_INDEX = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // What a cell does on the next edge
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_LEFT,
        OP_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cmd               cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [RD_W-1:0]    read_data;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_out_item;

    // Per-command result from the controller
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             rd_ok;
    } t_ctl_res;

endpackage
`default_nettype wire

// ===== sv/iidl_cell.sv =====
// One storage cell of the list chain.
`default_nettype none
module iidl_cell (
    input  wire                             i_clk,
    input  iidl_pkg::t_cell_op              i_op,
    input  wire [iidl_pkg::DATA_WIDTH-1:0]  i_load,
    input  wire [iidl_pkg::DATA_WIDTH-1:0]  i_left,
    input  wire [iidl_pkg::DATA_WIDTH-1:0]  i_right,
    output logic [iidl_pkg::DATA_WIDTH-1:0] o_data
);

    logic [iidl_pkg::DATA_WIDTH-1:0] r_data;
    logic [iidl_pkg::DATA_WIDTH-1:0] n_data;

    always_comb begin
        unique case (i_op)
            iidl_pkg::OP_LOAD:  n_data = i_load;
            iidl_pkg::OP_LEFT:  n_data = i_left;
            iidl_pkg::OP_RIGHT: n_data = i_right;
            default:            n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== sv/iidl_ctrl.sv =====
// Command decode, status and fill count; drives the op of every cell.
`default_nettype none
module iidl_ctrl (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_accept,
    input  iidl_pkg::t_cmd                           i_cmd,
    input  wire [iidl_pkg::POS_W-1:0]                i_pos,
    output iidl_pkg::t_cell_op [iidl_pkg::DEPTH-1:0] o_ops,
    output iidl_pkg::t_ctl_res                       o_res
);

    logic [iidl_pkg::CNT_W-1:0] r_count;
    logic [iidl_pkg::CNT_W-1:0] n_count;
    logic [iidl_pkg::CMP_W-1:0] pos_x;
    logic [iidl_pkg::CMP_W-1:0] cnt_x;
    logic [iidl_pkg::CMP_W-1:0] at;
    logic                       full;
    logic                       do_ins;
    logic                       do_del;
    logic                       rd_ok;
    iidl_pkg::t_status          status;

    assign pos_x = iidl_pkg::CMP_W'(i_pos);
    assign cnt_x = iidl_pkg::CMP_W'(r_count);
    assign full  = (r_count == iidl_pkg::CNT_W'(iidl_pkg::DEPTH));

    always_comb begin
        status  = iidl_pkg::ST_OK;
        n_count = r_count;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        rd_ok   = 1'b0;
        at      = pos_x;
        unique case (i_cmd)
            iidl_pkg::CMD_APPEND: begin
                at = cnt_x;
                if (full) begin
                    status = iidl_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + iidl_pkg::CNT_W'(1);
                end
            end
            iidl_pkg::CMD_INSERT: begin
                priority if (pos_x > cnt_x) begin
                    status = iidl_pkg::ST_BAD_INDEX;
                end else if (full) begin
                    status = iidl_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + iidl_pkg::CNT_W'(1);
                end
            end
            iidl_pkg::CMD_POP: begin
                if (r_count == '0) begin
                    status = iidl_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - iidl_pkg::CNT_W'(1);
                end
            end
            iidl_pkg::CMD_DELETE: begin
                if (pos_x >= cnt_x) begin
                    status = iidl_pkg::ST_BAD_INDEX;
                end else begin
                    do_del  = 1'b1;
                    n_count = r_count - iidl_pkg::CNT_W'(1);
                end
            end
            iidl_pkg::CMD_READ: begin
                if (pos_x >= cnt_x) begin
                    status = iidl_pkg::ST_BAD_INDEX;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            default: begin
                // unused codes: no change, status ok
            end
        endcase
    end

    // Cells at the target load or open a gap (insert) / close it (delete)
    always_comb begin
        for (int i = 0; i < iidl_pkg::DEPTH; i++) begin
            o_ops[i] = iidl_pkg::OP_HOLD;
            if (i_accept && do_ins) begin
                if (iidl_pkg::CMP_W'(i) == at) begin
                    o_ops[i] = iidl_pkg::OP_LOAD;
                end else if (iidl_pkg::CMP_W'(i) > at) begin
                    o_ops[i] = iidl_pkg::OP_LEFT;
                end
            end else if (i_accept && do_del) begin
                if (iidl_pkg::CMP_W'(i) >= at) begin
                    o_ops[i] = iidl_pkg::OP_RIGHT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_res.status = status;
    assign o_res.count  = n_count;
    assign o_res.rd_ok  = rd_ok;

endmodule
`default_nettype wire

// ===== sv/indexed_insert_delete_list.sv =====
// Top level of the indexed insert/delete list: cell chain, control, result register.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | i_in_valid/o_in_stall | i_in_item  (cmd, position, value)
//  out     | out | o_out_valid/i_out_stall | o_out_item (read_data, status, count)
//
// One item per cycle: a command is decoded and all cells shift, load or hold
// on the edge that accepts it; its result sits in the output register from
// the next cycle on. The input stalls only while a result waits and the out
// side stalls. Reset clears the fill count and the output valid; cell
// contents stay undefined until written.
`default_nettype none
module indexed_insert_delete_list (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  iidl_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output iidl_pkg::t_out_item  o_out_item
);

    logic                                          accept;
    iidl_pkg::t_cell_op [iidl_pkg::DEPTH-1:0]      ops;
    iidl_pkg::t_ctl_res                            res;
    logic [iidl_pkg::DEPTH-1:0][iidl_pkg::DATA_WIDTH-1:0] cell_data;
    logic [iidl_pkg::DATA_WIDTH-1:0]               load_data;
    logic [iidl_pkg::DATA_WIDTH-1:0]               rd_mux;
    logic [iidl_pkg::CMP_W-1:0]                    pos_x;

    logic                r_out_valid;
    iidl_pkg::t_out_item r_out_item;
    iidl_pkg::t_out_item n_out_item;

    // Result register frees the input unless a result is held by a stall
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign load_data = iidl_pkg::DATA_WIDTH'(i_in_item.value);
    assign pos_x     = iidl_pkg::CMP_W'(i_in_item.position);

    iidl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_in_item.cmd),
        .i_pos    (i_in_item.position),
        .o_ops    (ops),
        .o_res    (res)
    );

    // Chain: each cell sees its lower neighbor (left) and upper one (right)
    for (genvar g = 0; g < iidl_pkg::DEPTH; g++) begin : g_cell
        logic [iidl_pkg::DATA_WIDTH-1:0] left_d;
        logic [iidl_pkg::DATA_WIDTH-1:0] right_d;
        if (g == 0) begin : g_lo
            assign left_d = load_data;
        end else begin : g_mid_lo
            assign left_d = cell_data[g-1];
        end
        if (g == iidl_pkg::DEPTH - 1) begin : g_hi
            assign right_d = cell_data[g];
        end else begin : g_mid_hi
            assign right_d = cell_data[g+1];
        end
        iidl_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (ops[g]),
            .i_load  (load_data),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[g])
        );
    end

    // Read select: one-hot AND-OR over the cells
    always_comb begin
        rd_mux = '0;
        for (int i = 0; i < iidl_pkg::DEPTH; i++) begin
            if (iidl_pkg::CMP_W'(i) == pos_x) begin
                rd_mux = rd_mux | cell_data[i];
            end
        end
    end

    always_comb begin
        n_out_item.read_data = res.rd_ok ? iidl_pkg::RD_W'(rd_mux) : '0;
        n_out_item.status    = res.status;
        n_out_item.count     = iidl_pkg::COUNT_W'(res.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

// ===== sv/iidl_checker.sv =====
// Port-level checks for the indexed insert/delete list, bound to the top level.
`default_nettype none
module iidl_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input iidl_pkg::t_in_item  i_in_item,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input iidl_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != iidl_pkg::ST_OK)
        |-> o_out_item.read_data == '0)
        else $error("read data nonzero on a failed command");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == iidl_pkg::ST_FULL)
        |-> o_out_item.count == iidl_pkg::COUNT_W'(iidl_pkg::DEPTH))
        else $error("full reported below capacity");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == iidl_pkg::ST_EMPTY)
        |-> o_out_item.count == '0)
        else $error("empty reported with entries stored");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind indexed_insert_delete_list iidl_checker u_iidl_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the indexed insert/delete list: directed table, then random commands.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iidl_pkg::*;

    // Command codes the block ignores
    localparam t_cmd CMD_SPARE5 = 3'd5;
    localparam t_cmd CMD_SPARE6 = 3'd6;
    localparam t_cmd CMD_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int HOLD_AFTER   = 150;   // items sent before the hold-off starts
    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result
    localparam int MAX_ROWS     = 64;    // room in the directed table
    localparam int OWED_SLOTS   = 64;    // room in the ring of owed results

    // One row of the directed table. A row with reps > 1 repeats its command
    // with fresh random data. has_res marks a row whose result is typed in.
    typedef struct {
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
        logic [31:0]      val;
        int               reps;
        bit               has_res;
        t_out_item        res;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    // Shadow copy of the list, updated on every accepted command
    logic [DATA_WIDTH-1:0] list_mem [DEPTH];
    int                    list_len = 0;

    // Results still owed by the block, oldest at owed_rd
    t_out_item owed [OWED_SLOTS];
    int        owed_wr = 0;
    int        owed_rd = 0;

    t_dir_row  dir_rows [MAX_ROWS];
    int        n_rows = 0;

    int mismatches  = 0;
    int quiet_count = 0;
    int n_sent      = 0;
    int burst_left  = 0;

    indexed_insert_delete_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow list: apply one command, return the result it must produce.
    // A failing command leaves the list untouched.
    // ------------------------------------------------------------------
    function automatic t_out_item list_step(t_in_item it);
        t_out_item r;
        int        at;
        r = '0;
        r.status = ST_OK;
        at = int'(it.position);
        case (it.cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = it.value[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            CMD_INSERT: begin
                // index check wins over the full check
                if (at > list_len) begin
                    r.status = ST_BAD_INDEX;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > at; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[at] = it.value[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            CMD_POP: begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    list_len--;
            end
            CMD_DELETE: begin
                if (at >= list_len) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (int k = at; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (at >= list_len)
                    r.status = ST_BAD_INDEX;
                else
                    r.read_data = RD_W'(list_mem[at]);
            end
            default: ;  // spare codes: no change, status ok
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    function automatic t_out_item make_res(logic [31:0] rd, t_status st, int cnt);
        t_out_item r;
        r.read_data = rd;
        r.status    = st;
        r.count     = COUNT_W'(cnt);
        return r;
    endfunction

    // Directed row with a typed-in result
    task automatic row_res(t_cmd c, int p, logic [31:0] v, logic [31:0] rd, t_status st,
                           int cnt);
        t_dir_row row;
        row.cmd     = c;
        row.pos     = POS_W'(p);
        row.val     = v;
        row.reps    = 1;
        row.has_res = 1'b1;
        row.res     = make_res(rd, st, cnt);
        dir_rows[n_rows] = row;
        n_rows++;
    endtask

    // Directed row checked against the shadow list
    task automatic row_pred(t_cmd c, int p, logic [31:0] v, int reps);
        t_dir_row row;
        row.cmd     = c;
        row.pos     = POS_W'(p);
        row.val     = v;
        row.reps    = reps;
        row.has_res = 1'b0;
        row.res     = '0;
        dir_rows[n_rows] = row;
        n_rows++;
    endtask

    // ------------------------------------------------------------------
    // Sender. Items go out in bursts of random length; between most bursts the
    // valid drops for a random gap. Each negedge sees at most one write to
    // in_valid, so a valid that stays high between items is never toggled.
    // ------------------------------------------------------------------
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
    endtask

    // Offer one item and hold it until the handshake; then log what it owes.
    task automatic send_cmd(t_in_item it, bit has_res, t_out_item res);
        t_out_item pred;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        pred = list_step(it);
        owed[owed_wr % OWED_SLOTS] = has_res ? res : pred;
        owed_wr++;
        n_sent++;
    endtask

    // Random command. Fill mode leans on append/insert, drain mode on
    // delete/pop, so the list swings between empty and full. Most positions
    // are legal for the current length; some are anything in the field.
    function automatic t_in_item pick_cmd(bit fill_mode);
        t_in_item it;
        int       r;
        r = $urandom_range(99);
        if (fill_mode)
            it.cmd = (r < 35) ? CMD_APPEND : (r < 65) ? CMD_INSERT : (r < 82) ? CMD_READ :
                     (r < 90) ? CMD_DELETE : (r < 97) ? CMD_POP : CMD_SPARE5;
        else
            it.cmd = (r < 10) ? CMD_APPEND : (r < 22) ? CMD_INSERT : (r < 45) ? CMD_READ :
                     (r < 72) ? CMD_DELETE : (r < 97) ? CMD_POP : CMD_SPARE5;
        if (it.cmd == CMD_SPARE5)
            it.cmd = t_cmd'($urandom_range(CMD_SPARE5, CMD_SPARE7));

        if ($urandom_range(99) < 15)
            it.position = POS_W'($urandom_range(31));
        else if (it.cmd == CMD_INSERT)
            it.position = POS_W'($urandom_range(list_len));
        else if (list_len > 0)
            it.position = POS_W'($urandom_range(list_len - 1));
        else
            it.position = '0;

        r = $urandom_range(15);
        it.value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Receiver stall. Runs of random length in one of four moods: open,
    // light, heavy, alternating. Once, after HOLD_AFTER items, it holds off
    // for HOLD_CYCLES straight so the result register fills and the block
    // pushes back on its input.
    // ------------------------------------------------------------------
    initial begin
        int  mood;
        int  run_left;
        int  hold_left;
        bit  hold_done;
        bit  flip;
        mood      = 0;
        run_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        flip      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (!hold_done && n_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    mood     = $urandom_range(3);
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                flip = ~flip;
                case (mood)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(3) == 0);
                    2:       out_stall <= ($urandom_range(9) < 7);
                    default: out_stall <= flip;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker and handshake watchdog counter. Everything is read at
    // the rising edge, before the block's own updates land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        bit        in_take;
        bit        out_take;
        in_take  = i_rst_n && in_valid && !in_stall;
        out_take = i_rst_n && out_valid && !out_stall;
        quiet_count <= (in_take || out_take) ? 0 : quiet_count + 1;
        if (out_take) begin
            if (owed_wr == owed_rd) begin
                $display("%0t: result with nothing owed: %p", $time, out_item);
                mismatches <= mismatches + 1;
            end else begin
                want = owed[owed_rd % OWED_SLOTS];
                owed_rd++;
                if (out_item.read_data !== want.read_data ||
                    out_item.status !== want.status ||
                    out_item.count !== want.count) begin
                    $display({"%0t: mismatch read_data exp %h got %h, ",
                              "status exp %0d got %0d, count exp %0d got %0d"},
                             $time, want.read_data, out_item.read_data, want.status,
                             out_item.status, want.count, out_item.count);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin
        while (quiet_count < QUIET_LIMIT)
            @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item it;
        bit       fill_mode;
        int       mode_left;

        // Empty-list errors first, then a small list with extreme data
        row_res (CMD_READ,   0,  32'h0,         32'h0,         ST_BAD_INDEX, 0);
        row_res (CMD_DELETE, 0,  32'h0,         32'h0,         ST_BAD_INDEX, 0);
        row_res (CMD_POP,    0,  32'h0,         32'h0,         ST_EMPTY,     0);
        row_res (CMD_INSERT, 1,  32'h1234_5678, 32'h0,         ST_BAD_INDEX, 0);
        row_res (CMD_INSERT, 0,  32'hFFFF_FFFF, 32'h0,         ST_OK,        1);
        row_res (CMD_APPEND, 31, 32'h0,         32'h0,         ST_OK,        2);
        row_res (CMD_READ,   0,  32'h0,         32'hFFFF_FFFF, ST_OK,        2);
        row_res (CMD_READ,   1,  32'hFFFF_FFFF, 32'h0,         ST_OK,        2);
        row_res (CMD_SPARE5, 31, 32'hFFFF_FFFF, 32'h0,         ST_OK,        2);
        row_res (CMD_SPARE7, 0,  32'hDEAD_BEEF, 32'h0,         ST_OK,        2);
        row_pred(CMD_INSERT, 1,  32'hA5A5_A5A5, 1);
        row_res (CMD_READ,   31, 32'h0,         32'h0,         ST_BAD_INDEX, 3);
        row_pred(CMD_DELETE, 0,  32'h0,         1);
        // Fill to the top, then every way of bumping into full
        row_pred(CMD_APPEND, 0,  32'h0,         DEPTH - 2);
        row_res (CMD_APPEND, 0,  32'h5555_5555, 32'h0,         ST_FULL,      DEPTH);
        row_res (CMD_INSERT, DEPTH, 32'h1,      32'h0,         ST_FULL,      DEPTH);
        row_res (CMD_INSERT, DEPTH + 1, 32'h2,  32'h0,         ST_BAD_INDEX, DEPTH);
        row_res (CMD_INSERT, 0,  32'h3,         32'h0,         ST_FULL,      DEPTH);
        row_pred(CMD_READ,   DEPTH - 1, 32'h0,  1);
        row_res (CMD_READ,   DEPTH, 32'h0,      32'h0,         ST_BAD_INDEX, DEPTH);
        // Delete at both ends, insert at the end, then drain past empty
        row_pred(CMD_DELETE, DEPTH - 1, 32'h0,  1);
        row_pred(CMD_DELETE, 0,  32'h0,         1);
        row_pred(CMD_INSERT, DEPTH - 2, 32'hCAFE_F00D, 1);
        row_pred(CMD_POP,    0,  32'h0,         DEPTH);
        row_res (CMD_SPARE6, 0,  32'h0,         32'h0,         ST_OK,        0);

        // Synchronous reset held low, then released
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < n_rows; n++) begin
            for (int k = 0; k < dir_rows[n].reps; k++) begin
                it.cmd      = dir_rows[n].cmd;
                it.position = dir_rows[n].pos;
                it.value    = (dir_rows[n].reps > 1) ? $urandom : dir_rows[n].val;
                pace_sender();
                send_cmd(it, dir_rows[n].has_res, dir_rows[n].res);
            end
        end

        // Random commands, swinging between fill and drain phases
        fill_mode = 1'b1;
        mode_left = $urandom_range(20, 60);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                fill_mode = ~fill_mode;
                mode_left = $urandom_range(20, 60);
            end
            mode_left--;
            it = pick_cmd(fill_mode);
            pace_sender();
            send_cmd(it, 1'b0, '0);
        end

        @(negedge i_clk);
        in_valid <= 1'b0;

        // Wait for every owed result, then let the pipeline settle
        while (owed_wr != owed_rd)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && owed_wr == owed_rd)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== indexed_insert_delete_list.f =====
sv/iidl_pkg.sv
sv/iidl_cell.sv
sv/iidl_ctrl.sv
sv/indexed_insert_delete_list.sv
sv/iidl_checker.sv
tb/testbench.sv
